// ----- rtl/core/sca_pkg.sv -----
// Shared types, constants and codes of the size-class arena allocator.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package sca_pkg;

  localparam int unsigned MaxClassBytes = 256;
  localparam int unsigned HeapGranules  = 4096;
  localparam int unsigned GranuleBytes  = 16;

  localparam int unsigned NumClasses = MaxClassBytes / GranuleBytes;
  localparam int unsigned ClsW       = $clog2(NumClasses);
  localparam int unsigned GranW      = $clog2(HeapGranules);
  // Pointer width holds the empty marker one above the last granule.
  localparam int unsigned PtrW       = GranW + 1;
  localparam int unsigned SizeGW     = 13;
  localparam int unsigned CapW       = 17;
  localparam int unsigned BytesW     = 16;

  localparam logic [PtrW-1:0] EmptyMark  = PtrW'(HeapGranules);
  localparam logic [CapW-1:0] CapReset   = CapW'(65536);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_REGION = 2'd1,
    ST_DELEGATED     = 2'd2,
    ST_NULL_FREE     = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_e;

  typedef struct packed {
    opcode_e                opcode;
    logic [BytesW-1:0]      request_bytes;
    logic [GranW-1:0]       block_granule;
    logic                   block_present;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [GranW-1:0]       result_granule;
    logic                   from_free_list;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch request, read class head and link
    logic commit;   // update lists and bump pointer, load result register
  } dp_cmd_t;

endpackage

// ----- rtl/core/sca_ctrl.sv -----
// Controller of the size-class arena allocator: two-state sequencer and
// result valid flag. Depends on sca_pkg.
`timescale 1ns / 1ps

module sca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sca_pkg::dp_cmd_t  cmd_o
);

  sca_pkg::fsm_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sca_pkg::FSM_IDLE: begin
        if (in_valid_i) state_d = sca_pkg::FSM_EXEC;
      end
      sca_pkg::FSM_EXEC: begin
        if (!out_valid_q || out_ready_i) state_d = sca_pkg::FSM_IDLE;
      end
      default: state_d = sca_pkg::FSM_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      sca_pkg::FSM_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      sca_pkg::FSM_EXEC: begin
        cmd_o.commit = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Hold the result valid until taken; a commit refills it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sca_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/sca_dp.sv -----
// Datapath of the size-class arena allocator: capacity register, class heads,
// link memory, bump pointer and result register. Depends on sca_pkg.
`timescale 1ns / 1ps

module sca_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sca_pkg::dp_cmd_t              cmd_i,
  input  sca_pkg::req_t                 req_i,
  input  logic                          cfg_we_i,
  input  logic [sca_pkg::CapW-1:0]      cfg_data_i,
  output sca_pkg::rsp_t                 rsp_o
);

  localparam int unsigned NC    = sca_pkg::NumClasses;
  localparam int unsigned ClsW  = sca_pkg::ClsW;
  localparam int unsigned GranW = sca_pkg::GranW;
  localparam int unsigned PtrW  = sca_pkg::PtrW;
  localparam int unsigned SzW   = sca_pkg::SizeGW;

  logic [sca_pkg::CapW-1:0] cap_q;
  logic [PtrW-1:0]          heads_q [NC];
  logic [PtrW-1:0]          used_q, used_d;
  logic [PtrW-1:0]          links [sca_pkg::HeapGranules];

  // Request captured at accept.
  sca_pkg::opcode_e   op_q;
  logic               present_q;
  logic [GranW-1:0]   gran_q;
  logic               oversize_q;
  logic [ClsW-1:0]    cls_q;
  logic [PtrW-1:0]    head_q;
  logic [PtrW-1:0]    link_rd_q;

  sca_pkg::rsp_t      rsp_q, rsp_d;

  // Size decode in granules; zero bytes counts as one granule.
  logic [sca_pkg::BytesW:0] sum_c;
  logic [SzW-1:0]           size_g_c;
  logic                     oversize_c;
  logic [ClsW-1:0]          cls_c;
  logic [PtrW-1:0]          head_c;

  assign sum_c      = {1'b0, req_i.request_bytes} + (sca_pkg::BytesW+1)'(15);
  assign size_g_c   = (req_i.request_bytes == '0) ? SzW'(1) : SzW'(sum_c >> 4);
  assign oversize_c = size_g_c > SzW'(NC);
  assign cls_c      = ClsW'(size_g_c - SzW'(1));
  assign head_c     = heads_q[cls_c];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= req_i.opcode;
      present_q  <= req_i.block_present;
      gran_q     <= req_i.block_granule;
      oversize_q <= oversize_c;
      cls_q      <= cls_c;
      head_q     <= head_c;
    end
  end

  // Link memory: read at accept, written by a push at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) link_rd_q <= links[head_c[GranW-1:0]];
  end

  logic push_c, pop_c, bump_c;

  always_ff @(posedge clk_i) begin
    if (push_c) links[gran_q] <= head_q;
  end

  // Bump fit check in granules; capacity saturates at the heap size.
  logic [PtrW-1:0] cap_g_c;
  logic [PtrW:0]   need_c;
  logic [PtrW-1:0] next_head_c;

  assign cap_g_c     = cap_q[sca_pkg::CapW-1] ? sca_pkg::EmptyMark
                                              : PtrW'(cap_q[sca_pkg::CapW-2:4]);
  assign need_c      = {1'b0, used_q} + (PtrW+1)'(cls_q) + (PtrW+1)'(1);
  assign next_head_c = link_rd_q[PtrW-1] ? sca_pkg::EmptyMark : link_rd_q;

  always_comb begin
    rsp_d  = '{status: sca_pkg::ST_OK, result_granule: '0, from_free_list: 1'b0};
    push_c = 1'b0;
    pop_c  = 1'b0;
    bump_c = 1'b0;
    used_d = used_q;
    if (op_q == sca_pkg::OP_ALLOC) begin
      if (oversize_q) begin
        rsp_d.status = sca_pkg::ST_DELEGATED;
      end else if (!head_q[PtrW-1]) begin
        pop_c                = cmd_i.commit;
        rsp_d.result_granule = head_q[GranW-1:0];
        rsp_d.from_free_list = 1'b1;
      end else if (need_c <= (PtrW+1)'(cap_g_c)) begin
        bump_c               = cmd_i.commit;
        rsp_d.result_granule = used_q[GranW-1:0];
        used_d               = PtrW'(need_c);
      end else begin
        rsp_d.status = sca_pkg::ST_OUT_OF_REGION;
      end
    end else begin
      if (!present_q) begin
        rsp_d.status = sca_pkg::ST_NULL_FREE;
      end else if (oversize_q) begin
        rsp_d.status = sca_pkg::ST_DELEGATED;
      end else begin
        push_c = cmd_i.commit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= sca_pkg::CapReset;
      used_q <= '0;
      for (int i = 0; i < NC; i++) heads_q[i] <= sca_pkg::EmptyMark;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (bump_c) used_q <= used_d;
      if (pop_c) heads_q[cls_q] <= next_head_c;
      else if (push_c) heads_q[cls_q] <= PtrW'(gran_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

// ----- rtl/core/size_class_arena_allocator_top.sv -----
// Top level of the size-class arena allocator: stream ports, controller and
// datapath. Depends on sca_pkg, sca_ctrl and sca_dp.
`timescale 1ns / 1ps

// Segregated free-list bump allocator over one arena of 4096 granules of 16
// bytes. Each request word (allocate or free) yields exactly one result word.
// Sizes round up to 16 bytes (zero counts as 16); sizes above 256 bytes are
// reported as delegated. An allocation pops the LIFO free list of its size
// class, or else bumps the used pointer when it fits within capacity_bytes
// (saturating at the arena size), or else reports out of region. A free
// pushes the block onto its class list; a null free is reported and ignored.
// On accept, the idle state reads the class head and, through the registered
// read port of the link memory, the head's successor; the exec state then
// commits the list and pointer update and loads the result register. The
// result register lets the next word be accepted while a result waits; a
// commit stalls only while that register is full and not being taken. Write
// the capacity register only while the block is idle. No clearing pass is
// needed after reset: link memory data is only used at entries a push wrote.

module size_class_arena_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] request_bytes, [27:16] block_granule,
                                      // [28] block_present, [31:29] zero
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] result_granule, [12] from_free_list,
                                      // [15:13] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // Capacity register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  sca_pkg::dp_cmd_t cmd;
  sca_pkg::req_t    req;
  sca_pkg::rsp_t    rsp;

  // Unpack the request word.
  assign req.opcode        = sca_pkg::opcode_e'(s_axis_tuser[0]);
  assign req.request_bytes = s_axis_tdata[15:0];
  assign req.block_granule = s_axis_tdata[27:16];
  assign req.block_present = s_axis_tdata[28];

  // Capacity writes are taken at any time.
  assign cfg_ready_o = 1'b1;

  sca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sca_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp)
  );

  // Pack the result word.
  assign m_axis_tdata = {3'b000, rsp.from_free_list, rsp.result_granule};
  assign m_axis_tuser = rsp.status;

  // One request in flight: an accept closes the input for the next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // Only a successful allocation carries a granule or the reuse flag.
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != sca_pkg::ST_OK)) |-> (m_axis_tdata == 16'd0))
    else $error("failed request carries a nonzero payload");

  // A result is loaded only by the commit that follows an accept.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_axis_tvalid)) |-> (!$past(s_axis_tready)))
    else $error("result appeared without a committed request");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the size-class arena allocator top level.
// Depends on sca_pkg and the RTL; predicts every result word in-line and checks it.
`timescale 1ns / 1ps

module testbench;
  import sca_pkg::*;

  // Pause after the last expected result before touching the capacity register
  // or ending the run: it covers the result register, with margin.
  localparam int unsigned DrainCycles = 8;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int unsigned StallLimit  = 4000;

  typedef struct packed {
    status_e          status;
    logic [GranW-1:0] granule;
    logic             reused;
  } outcome_t;

  typedef struct {
    logic [GranW-1:0]  granule;
    logic [BytesW-1:0] nbytes;
  } block_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;
  logic [0:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CapW-1:0]   cfg_data_i;

  // Predicted allocator state: class list heads, per-granule links, bump pointer.
  logic [PtrW-1:0]   list_head [NumClasses];
  logic [PtrW-1:0]   list_link [HeapGranules];
  logic [SizeGW-1:0] bump_used;
  logic [CapW-1:0]   arena_capacity;

  outcome_t          pending_outcomes [$];
  block_t            live_blocks [$];
  block_t            freed_blocks [$];

  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  bit                tx_holding;
  int unsigned       mismatches;
  int unsigned       stall_cycles;
  int unsigned       words_sent, pops, bumps, out_of_region, delegated, null_frees, pushes;

  size_class_arena_allocator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] request_bytes, [27:16] block_granule,
                                     // [28] block_present, [31:29] zero
    .s_axis_tuser  (s_axis_tuser),   // [0] opcode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [11:0] result_granule, [12] from_free_list,
                                     // [15:13] zero
    .m_axis_tuser  (m_axis_tuser),   // [1:0] status
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the result word of one request and advance the predicted state.
  // Allocate: oversize first, then pop the class list, then bump within capacity.
  // Free: null pointer first, then oversize, then push; a 12-bit granule is
  // always inside the arena, so the outside-the-arena case cannot arise.
  function automatic outcome_t resolve_request(opcode_e op, logic [BytesW-1:0] nbytes,
                                               logic [GranW-1:0] gran, logic present);
    outcome_t        o;
    int unsigned     rounded, slot, room, need;
    logic [PtrW-1:0] head;
    o.status  = ST_OK;
    o.granule = '0;
    o.reused  = 1'b0;
    rounded = (nbytes == '0) ? GranuleBytes
            : ((int'(nbytes) + GranuleBytes - 1) / GranuleBytes) * GranuleBytes;
    if (op == OP_FREE && !present) begin
      o.status = ST_NULL_FREE;
    end else if (rounded > MaxClassBytes) begin
      o.status = ST_DELEGATED;
    end else if (op == OP_FREE) begin
      slot = rounded / GranuleBytes - 1;
      list_link[gran] = list_head[slot];
      list_head[slot] = {1'b0, gran};
    end else begin
      slot = rounded / GranuleBytes - 1;
      head = list_head[slot];
      if (head < EmptyMark) begin
        list_head[slot] = list_link[head[GranW-1:0]];
        o.granule = head[GranW-1:0];
        o.reused  = 1'b1;
      end else begin
        // Saturate the capacity at the arena size.
        room = (arena_capacity > HeapGranules * GranuleBytes) ? HeapGranules * GranuleBytes
                                                               : arena_capacity;
        need = bump_used * GranuleBytes + rounded;
        if (need > room) begin
          o.status = ST_OUT_OF_REGION;
        end else begin
          o.granule = bump_used[GranW-1:0];
          bump_used = bump_used + SizeGW'(rounded / GranuleBytes);
        end
      end
    end
    return o;
  endfunction

  // Pick a byte count that rounds to the same class as the original request.
  function automatic logic [BytesW-1:0] same_class_bytes(logic [BytesW-1:0] orig);
    int unsigned rounded;
    rounded = (orig == '0) ? GranuleBytes
            : ((int'(orig) + GranuleBytes - 1) / GranuleBytes) * GranuleBytes;
    if (rounded == GranuleBytes && $urandom_range(3) == 0) return '0;
    return BytesW'($urandom_range(rounded, rounded - GranuleBytes + 1));
  endfunction

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Drop tvalid when no word follows in this time step.
  task automatic park_request_port();
    if (tx_holding) begin
      s_axis_tvalid <= 1'b0;
      tx_holding = 1'b0;
    end
  endtask

  // Send one request word, then predict its result once it is accepted.
  // Keep tvalid high afterwards so a following word can go out back to back.
  task automatic send_request(input opcode_e op, input logic [BytesW-1:0] nbytes,
                              input logic [GranW-1:0] gran, input logic present,
                              output outcome_t got);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, present, gran, nbytes};
    s_axis_tuser  <= op;
    tx_holding = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    got = resolve_request(op, nbytes, gran, present);
    pending_outcomes.push_back(got);
    words_sent++;
    case (got.status)
      ST_OK: begin
        if (op == OP_FREE) pushes++;
        else if (got.reused) pops++;
        else bumps++;
      end
      ST_OUT_OF_REGION: out_of_region++;
      ST_DELEGATED:     delegated++;
      default:          null_frees++;
    endcase
  endtask

  // Let every expected result arrive, then the block's pipeline empty out.
  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    park_request_port();
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    arena_capacity = value;
  endtask

  // Field extremes, every operation, null and oversize frees, double free, LIFO reuse.
  task automatic test_directed_edges();
    outcome_t got;
    send_request(OP_ALLOC, 16'd0,     12'd0,    1'b0, got);  // zero counts as 16
    send_request(OP_ALLOC, 16'd1,     12'hFFF,  1'b1, got);
    send_request(OP_ALLOC, 16'd256,   12'd0,    1'b0, got);  // largest class
    send_request(OP_ALLOC, 16'd257,   12'd0,    1'b0, got);  // just oversize
    send_request(OP_ALLOC, 16'hFFFF,  12'hFFF,  1'b1, got);
    send_request(OP_FREE,  16'hFFFF,  12'hFFF,  1'b0, got);  // null pointer wins
    send_request(OP_FREE,  16'd0,     12'd0,    1'b0, got);
    send_request(OP_FREE,  16'd300,   12'd5,    1'b1, got);  // oversize free
    send_request(OP_FREE,  16'd256,   12'd2,    1'b1, got);
    send_request(OP_FREE,  16'd0,     12'd0,    1'b1, got);
    send_request(OP_FREE,  16'd16,    12'd1,    1'b1, got);
    send_request(OP_ALLOC, 16'd10,    12'd0,    1'b0, got);  // pops granule 1
    send_request(OP_ALLOC, 16'd16,    12'd0,    1'b0, got);  // pops granule 0
    send_request(OP_ALLOC, 16'd241,   12'd0,    1'b0, got);  // pops granule 2
    send_request(OP_ALLOC, 16'd16,    12'd0,    1'b0, got);  // list empty: bump
    send_request(OP_FREE,  16'd240,   12'hFFF,  1'b1, got);
    send_request(OP_FREE,  16'd225,   12'hFFF,  1'b1, got);  // same block again
    send_request(OP_ALLOC, 16'd240,   12'd0,    1'b0, got);
    send_request(OP_ALLOC, 16'd233,   12'd0,    1'b0, got);
    send_request(OP_ALLOC, 16'd240,   12'd0,    1'b0, got);
  endtask

  // Exact fit at the bump limit, one granule past it, and a zero capacity
  // under which only list pops can succeed.
  task automatic test_capacity_limits();
    outcome_t got;
    write_capacity(CapW'(bump_used * GranuleBytes + 32));
    send_request(OP_ALLOC, 16'd32,  12'd0, 1'b0, got);  // fits exactly
    send_request(OP_ALLOC, 16'd0,   12'd0, 1'b0, got);  // one granule too many
    write_capacity('0);
    send_request(OP_ALLOC, 16'd48,  12'd0, 1'b0, got);
    send_request(OP_FREE,  16'd48,  12'd7, 1'b1, got);
    send_request(OP_ALLOC, 16'd33,  12'd0, 1'b0, got);  // reuse still works
    send_request(OP_ALLOC, 16'd256, 12'd0, 1'b0, got);
  endtask

  // Mostly well-formed alloc/free traffic over tracked blocks, with double
  // frees, null and oversize frees and stray pushes mixed in.
  task automatic test_random_traffic(input int unsigned words);
    int unsigned       counted, pick, idx;
    block_t            blk;
    outcome_t          got;
    logic [BytesW-1:0] nbytes;
    counted = 0;
    while (counted < words) begin
      pick = $urandom_range(99);
      if ((pick < 25 || live_blocks.size() > 64) && live_blocks.size() != 0) begin
        idx = $urandom_range(live_blocks.size() - 1);
        blk = live_blocks[idx];
        live_blocks.delete(idx);
        send_request(OP_FREE, same_class_bytes(blk.nbytes), blk.granule, 1'b1, got);
        freed_blocks.push_back(blk);
        if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
      end else if (pick >= 25 && pick < 30 && freed_blocks.size() != 0) begin
        blk = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
        send_request(OP_FREE, same_class_bytes(blk.nbytes), blk.granule, 1'b1, got);
      end else if (pick >= 30 && pick < 37) begin
        // Null free: reported and ignored by the block.
        send_request(OP_FREE, BytesW'($urandom), GranW'($urandom), 1'b0, got);
      end else if (pick >= 37 && pick < 42) begin
        send_request(OP_FREE, BytesW'($urandom_range(16'hFFFF, MaxClassBytes + 1)),
                     GranW'($urandom), 1'b1, got);
      end else if (pick >= 42 && pick < 47) begin
        send_request(OP_FREE, BytesW'($urandom_range(MaxClassBytes)),
                     GranW'($urandom), 1'b1, got);
      end else begin
        nbytes = (pick < 52) ? BytesW'($urandom) : BytesW'($urandom_range(MaxClassBytes));
        send_request(OP_ALLOC, nbytes, GranW'($urandom), 1'($urandom), got);
        if (got.status == ST_OK) live_blocks.push_back('{got.granule, nbytes});
      end
      counted++;
    end
  endtask

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result word with no request pending: tuser %0d tdata %0h",
               m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[GranW-1:0] !== want.granule) begin
          $error("result_granule: expected %0d, got %0d", want.granule,
                 m_axis_tdata[GranW-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[GranW] !== want.reused) begin
          $error("from_free_list: expected %0d, got %0d", want.reused, m_axis_tdata[GranW]);
          mismatches++;
        end
      end
    end
  end

  // Stall the result stream at the current idling rate.
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  // Hold a count of cycles without any handshake; give up when it reaches the limit.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ALLOC;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    tx_holding    = 1'b0;
    stall_cycles  = 0;
    mismatches    = 0;
    words_sent = 0; pops = 0; bumps = 0; out_of_region = 0;
    delegated = 0; null_frees = 0; pushes = 0;
    foreach (list_head[i]) list_head[i] = EmptyMark;
    foreach (list_link[i]) list_link[i] = '0;
    bump_used      = '0;
    arena_capacity = CapReset;

    set_idling(15, 72);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_capacity_limits();

    // Capacity above the arena size saturates.
    write_capacity({CapW{1'b1}});
    test_random_traffic(275);

    // Put the bump limit a little past the current pointer so it is reached.
    set_idling(72, 15);
    write_capacity(CapW'(bump_used * GranuleBytes + $urandom_range(4000, 1000)));
    test_random_traffic(275);

    set_idling(0, 0);
    write_capacity(CapReset);
    test_random_traffic(275);

    park_request_port();
    wait_drained();

    $display("Covered %0d request words: %0d pops, %0d bumps, %0d pushes,",
             words_sent, pops, bumps, pushes);
    $display("  %0d out of region, %0d delegated, %0d null frees, final bump pointer %0d",
             out_of_region, delegated, null_frees, bump_used);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sca_pkg.sv
rtl/core/sca_ctrl.sv
rtl/core/sca_dp.sv
rtl/core/size_class_arena_allocator_top.sv
dv/testbench.sv
